// ----- src/email_address_syntax_check_unit_defines.svh -----
// assertion macros for the email address syntax check unit
// no dependencies; included by the modules that carry assertions
`ifndef EMAIL_ADDRESS_SYNTAX_CHECK_UNIT_DEFINES_SVH
`define EMAIL_ADDRESS_SYNTAX_CHECK_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define EASC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("easc assertion failed");

// next-cycle implication, disabled while reset is low
`define EASC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("easc assertion failed");

`endif

// ----- src/easc_pkg.sv -----
// types, constants and character-class functions for the address checker
// no dependencies
package easc_pkg;

  localparam int unsigned LocalLimitW  = 7;
  localparam int unsigned DomainLimitW = 8;
  localparam int unsigned LabelLimitW  = 6;
  localparam int unsigned CfgDataW     = 8;
  localparam int unsigned CfgIndexW    = 2;

  localparam logic [LocalLimitW-1:0]  LocalLimitReset  = 7'd64;
  localparam logic [DomainLimitW-1:0] DomainLimitReset = 8'd255;
  localparam logic [LabelLimitW-1:0]  LabelLimitReset  = 6'd63;

  localparam logic [7:0] ChAt     = 8'h40;
  localparam logic [7:0] ChDot    = 8'h2E;
  localparam logic [7:0] ChHyphen = 8'h2D;

  typedef enum logic [1:0] {
    PH_LEAD   = 2'd0,
    PH_LOCAL  = 2'd1,
    PH_DOMAIN = 2'd2,
    PH_TRAIL  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_DOT    = 2'd1,
    KIND_HYPHEN = 2'd2,
    KIND_OTHER  = 2'd3
  } kind_e;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_LOCAL_LIMIT  = 2'd0,
    CFG_DOMAIN_LIMIT = 2'd1,
    CFG_LABEL_LIMIT  = 2'd2
  } cfg_index_e;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

  // ! # $ % & ' * + - / = ? ^ _ ` { | } ~
  function automatic logic is_local_special(input logic [7:0] c);
    logic hit;
    case (c)
      8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B, 8'h2D, 8'h2F,
      8'h3D, 8'h3F, 8'h5E, 8'h5F, 8'h60, 8'h7B, 8'h7C, 8'h7D, 8'h7E: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

// ----- src/easc_channels.sv -----
// valid/ready channel interfaces for the address checker
// depends on easc_pkg
interface easc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       final_byte;
  modport source (output valid, output text_byte, output final_byte, input ready);
  modport sink (input valid, input text_byte, input final_byte, output ready);
endinterface

interface easc_out_if;
  logic valid;
  logic ready;
  logic address_ok;
  modport source (output valid, output address_ok, input ready);
  modport sink (input valid, input address_ok, output ready);
endinterface

interface easc_cfg_if import easc_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CfgIndexW-1:0] reg_index;
  logic [CfgDataW-1:0]  wdata;
  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

// ----- src/email_address_syntax_check_unit.sv -----
// email address syntax checker: one address byte per item, one verdict per address
// depends on easc_pkg, easc_channels and email_address_syntax_check_unit_defines.svh
//
// usage:
//   in_ch   carries text_byte and final_byte; bytes of one address go in order,
//           final_byte marks the last one
//   out_ch  carries address_ok, one item for each address, after its final byte
//   cfg_ch  writes the three length limits (local, domain, label) by index;
//           index 3 is ignored; always ready, write only while the block is idle
// the final byte passes through the input register, then the result register, before its
// verdict shows on out_ch
// throughput: one byte per cycle except while a final byte waits (below); the per-byte
// state update is one pass of character-class logic plus a few narrow counter compares
// a stalled out_ch holds the result; the input register keeps draining non-final
// bytes, and only a final byte waits for the result register to free up
// reset: limits go to 64/255/63, scan state to the leading-whitespace phase,
// both pipeline registers empty
`include "email_address_syntax_check_unit_defines.svh"

module email_address_syntax_check_unit import easc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  easc_in_if.sink    in_ch,
  easc_cfg_if.sink   cfg_ch,
  easc_out_if.source out_ch
);

  // configuration registers
  logic [LocalLimitW-1:0]  local_limit_q;
  logic [DomainLimitW-1:0] domain_limit_q;
  logic [LabelLimitW-1:0]  label_limit_q;

  // input register
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;

  // scan state
  phase_e                  phase_q, phase_d;
  kind_e                   kind_q, kind_d;
  logic                    failed_q, failed_d;
  logic [LocalLimitW-1:0]  local_cnt_q, local_cnt_d;
  logic [DomainLimitW-1:0] domain_cnt_q, domain_cnt_d;
  logic [LabelLimitW-1:0]  label_cnt_q, label_cnt_d;
  logic                    dot_q, dot_d;

  // result register
  logic out_valid_q;
  logic out_ok_q;
  logic ok_d;

  logic out_free;
  logic advance;
  logic sp;
  logic do_local;

  // config port: always takes a write
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_limit_q  <= LocalLimitReset;
      domain_limit_q <= DomainLimitReset;
      label_limit_q  <= LabelLimitReset;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.reg_index)
        CFG_LOCAL_LIMIT:  local_limit_q  <= cfg_ch.wdata[LocalLimitW-1:0];
        CFG_DOMAIN_LIMIT: domain_limit_q <= cfg_ch.wdata[DomainLimitW-1:0];
        CFG_LABEL_LIMIT:  label_limit_q  <= cfg_ch.wdata[LabelLimitW-1:0];
        default: ;  // unused index, ignored
      endcase
    end
  end

  // handshake: a non-final byte always moves on, a final one needs the result slot
  assign out_free    = !out_valid_q || out_ch.ready;
  assign advance     = s1_valid_q && (!s1_last_q || out_free);
  assign in_ch.ready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_byte_q <= in_ch.text_byte;
      s1_last_q <= in_ch.final_byte;
    end
  end

  // per-byte scan update
  assign sp       = is_space(s1_byte_q);
  assign do_local = !sp && (phase_q == PH_LEAD || phase_q == PH_LOCAL);

  always_comb begin
    phase_d      = phase_q;
    kind_d       = kind_q;
    failed_d     = failed_q;
    local_cnt_d  = local_cnt_q;
    domain_cnt_d = domain_cnt_q;
    label_cnt_d  = label_cnt_q;
    dot_d        = dot_q;

    unique case (phase_q)
      PH_LEAD: begin
        if (!sp) phase_d = PH_LOCAL;
      end
      PH_LOCAL: begin
        if (sp) failed_d = 1'b1;
      end
      PH_DOMAIN: begin
        if (sp) begin
          phase_d = PH_TRAIL;
        end else begin
          // domain length, saturating at the limit
          if (domain_cnt_q >= domain_limit_q) failed_d = 1'b1;
          else domain_cnt_d = domain_cnt_q + 1'b1;
          if (s1_byte_q == ChDot) begin
            if (label_cnt_q == '0 || kind_q == KIND_HYPHEN) failed_d = 1'b1;
            dot_d       = 1'b1;
            label_cnt_d = '0;
            kind_d      = KIND_DOT;
          end else begin
            // hyphen may not open a label; anything else must be alphanumeric
            if (s1_byte_q == ChHyphen) begin
              if (label_cnt_q == '0) failed_d = 1'b1;
              kind_d = KIND_HYPHEN;
            end else begin
              if (!is_alnum(s1_byte_q)) failed_d = 1'b1;
              kind_d = KIND_OTHER;
            end
            if (label_cnt_q >= label_limit_q) failed_d = 1'b1;
            else label_cnt_d = label_cnt_q + 1'b1;
          end
        end
      end
      PH_TRAIL: begin
        if (!sp) failed_d = 1'b1;
      end
      default: ;
    endcase

    // local-part byte, shared by the first visible byte and the local phase
    if (do_local) begin
      if (s1_byte_q == ChAt) begin
        if (local_cnt_q == '0 || kind_q == KIND_DOT) failed_d = 1'b1;
        phase_d     = PH_DOMAIN;
        kind_d      = KIND_NONE;
        label_cnt_d = '0;
      end else begin
        if (local_cnt_q >= local_limit_q) failed_d = 1'b1;
        else local_cnt_d = local_cnt_q + 1'b1;
        if (s1_byte_q == ChDot) begin
          if (kind_q == KIND_NONE || kind_q == KIND_DOT) failed_d = 1'b1;
          kind_d = KIND_DOT;
        end else begin
          if (!is_alnum(s1_byte_q) && !is_local_special(s1_byte_q)) failed_d = 1'b1;
          kind_d = KIND_OTHER;
        end
      end
    end

    // verdict as of this byte
    ok_d = !failed_d && (phase_d == PH_DOMAIN || phase_d == PH_TRAIL) &&
           (label_cnt_d != '0) && (kind_d != KIND_HYPHEN) && dot_d;
  end

  // scan state: cleared after the final byte of each address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_LEAD;
      kind_q       <= KIND_NONE;
      failed_q     <= 1'b0;
      local_cnt_q  <= '0;
      domain_cnt_q <= '0;
      label_cnt_q  <= '0;
      dot_q        <= 1'b0;
    end else if (advance) begin
      if (s1_last_q) begin
        phase_q      <= PH_LEAD;
        kind_q       <= KIND_NONE;
        failed_q     <= 1'b0;
        local_cnt_q  <= '0;
        domain_cnt_q <= '0;
        label_cnt_q  <= '0;
        dot_q        <= 1'b0;
      end else begin
        phase_q      <= phase_d;
        kind_q       <= kind_d;
        failed_q     <= failed_d;
        local_cnt_q  <= local_cnt_d;
        domain_cnt_q <= domain_cnt_d;
        label_cnt_q  <= label_cnt_d;
        dot_q        <= dot_d;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_last_q) out_ok_q <= ok_d;
  end

  assign out_ch.valid      = out_valid_q;
  assign out_ch.address_ok = out_ok_q;

  // a final byte always lands in the result register
  `EASC_ASSERT_NEXT(a_final_gives_result, clk_i, rst_ni,
    advance && s1_last_q, out_valid_q)
  // state is back at the start after each address
  `EASC_ASSERT_NEXT(a_clear_after_final, clk_i, rst_ni,
    advance && s1_last_q, phase_q == PH_LEAD && !failed_q && local_cnt_q == '0)
  // nothing counted before the first visible byte
  `EASC_ASSERT_IMPL(a_lead_is_clean, clk_i, rst_ni,
    phase_q == PH_LEAD, local_cnt_q == '0 && domain_cnt_q == '0 && !dot_q)
  // domain counters stay at zero in the local part
  `EASC_ASSERT_IMPL(a_local_no_domain, clk_i, rst_ni,
    phase_q == PH_LOCAL, domain_cnt_q == '0 && label_cnt_q == '0)

endmodule

// ----- verif/tb_top.sv -----
// self-checking testbench for the email address syntax check unit
// depends on easc_pkg, the easc channel interfaces and email_address_syntax_check_unit
// drives address bytes with random bursts and stalls, predicts each verdict, checks in order
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import easc_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 8;
  localparam int RANDOM_BYTES  = 650;

  // index past the register list, the block must ignore it
  localparam logic [CfgIndexW-1:0] CFG_UNUSED = 2'd3;

  // space, tab, lf, cr
  localparam logic [31:0] BLANKS = {8'h20, 8'h09, 8'h0A, 8'h0D};
  // ! # $ % & ' * + - / = ? ^ _ ` { | } ~
  localparam int N_SPECIALS = 19;
  localparam logic [N_SPECIALS*8-1:0] SPECIALS = {
    8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B, 8'h2D, 8'h2F,
    8'h3D, 8'h3F, 8'h5E, 8'h5F, 8'h60, 8'h7B, 8'h7C, 8'h7D, 8'h7E
  };

  // ways a well-formed address gets broken
  typedef enum int {
    MUT_FLIP, MUT_INSERT, MUT_DROP, MUT_SECOND_AT,
    MUT_DOT_AT_EDGE, MUT_HYPHEN_AT_EDGE, MUT_INNER_BLANK, MUT_DOUBLE_DOT
  } mutation_e;

  // receiver back-pressure styles
  typedef enum int {RX_OPEN, RX_COIN, RX_TIGHT, RX_PERIODIC} rx_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  easc_in_if  in_ch ();
  easc_out_if out_ch ();
  easc_cfg_if cfg_ch ();

  email_address_syntax_check_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch)
  );

  always begin
    #(CLK_HALF) clk_i = 1'b1;
    #(CLK_HALF) clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // verdict predictor: own copy of the limits and of the per-address scan state
  // ---------------------------------------------------------------------------
  logic [LocalLimitW-1:0]  lim_local;
  logic [DomainLimitW-1:0] lim_domain;
  logic [LabelLimitW-1:0]  lim_label;

  phase_e     scan_ph;
  logic       addr_bad;
  logic [6:0] loc_cnt;
  logic [8:0] dom_cnt;
  logic [6:0] lab_cnt;
  kind_e      prev_kind;
  logic       dot_seen;

  logic pending_verdicts [$];   // expected address_ok values, oldest first

  int error_count;
  int bytes_sent;
  int addresses_checked;
  int valid_seen;
  int limit_writes;
  int burst_left;

  logic [7:0] addr_q [$];       // bytes of the address being sent

  function automatic bit byte_is_blank(input logic [7:0] c);
    for (int i = 0; i < 4; i++) begin
      if (BLANKS[i*8 +: 8] == c) return 1'b1;
    end
    return 1'b0;
  endfunction

  // top-bit bytes fall outside every range here, so they never count
  function automatic bit byte_is_alnum(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic bit byte_is_local_special(input logic [7:0] c);
    for (int i = 0; i < N_SPECIALS; i++) begin
      if (SPECIALS[i*8 +: 8] == c) return 1'b1;
    end
    return 1'b0;
  endfunction

  // append one byte to the address being built
  task automatic add_byte(input logic [7:0] c);
    addr_q.insert(addr_q.size(), c);
  endtask

  // back to the leading-whitespace phase, limits untouched
  task automatic clear_scan();
    scan_ph   = PH_LEAD;
    addr_bad  = 1'b0;
    loc_cnt   = '0;
    dom_cnt   = '0;
    lab_cnt   = '0;
    prev_kind = KIND_NONE;
    dot_seen  = 1'b0;
  endtask

  // one byte of the local part, or the at sign that closes it
  task automatic scan_local(input logic [7:0] c);
    if (c == ChAt) begin
      // empty local part or a trailing dot
      if (loc_cnt == 0 || prev_kind == KIND_DOT) addr_bad = 1'b1;
      scan_ph   = PH_DOMAIN;
      prev_kind = KIND_NONE;
      lab_cnt   = '0;
    end else begin
      // counter saturates at the limit, the overflow byte marks the address bad
      if (loc_cnt >= lim_local) addr_bad = 1'b1;
      else loc_cnt = loc_cnt + 1'b1;
      if (c == ChDot) begin
        // leading or doubled dot
        if (prev_kind == KIND_NONE || prev_kind == KIND_DOT) addr_bad = 1'b1;
        prev_kind = KIND_DOT;
      end else begin
        if (!byte_is_alnum(c) && !byte_is_local_special(c)) addr_bad = 1'b1;
        prev_kind = KIND_OTHER;
      end
    end
  endtask

  // advance the scan by one accepted byte; a final byte queues its verdict
  task automatic judge_byte(input logic [7:0] c, input logic fin);
    logic ok;
    case (scan_ph)
      PH_LEAD: begin
        if (!byte_is_blank(c)) begin
          scan_ph = PH_LOCAL;
          scan_local(c);
        end
      end
      PH_LOCAL: begin
        // whitespace inside the local part is fatal
        if (byte_is_blank(c)) addr_bad = 1'b1;
        else scan_local(c);
      end
      PH_DOMAIN: begin
        if (byte_is_blank(c)) begin
          // whitespace ends the domain, only more whitespace may follow
          scan_ph = PH_TRAIL;
        end else begin
          if (dom_cnt >= 9'(lim_domain)) addr_bad = 1'b1;
          else dom_cnt = dom_cnt + 1'b1;
          if (c == ChDot) begin
            // empty label or label ending in a hyphen
            if (lab_cnt == 0 || prev_kind == KIND_HYPHEN) addr_bad = 1'b1;
            dot_seen  = 1'b1;
            lab_cnt   = '0;
            prev_kind = KIND_DOT;
          end else begin
            if (c == ChHyphen) begin
              if (lab_cnt == 0) addr_bad = 1'b1;   // label starting with a hyphen
            end else if (!byte_is_alnum(c)) begin
              addr_bad = 1'b1;                     // includes a second at sign
            end
            if (lab_cnt >= 7'(lim_label)) addr_bad = 1'b1;
            else lab_cnt = lab_cnt + 1'b1;
            if (c == ChHyphen) prev_kind = KIND_HYPHEN;
            else prev_kind = KIND_OTHER;
          end
        end
      end
      default: begin
        if (!byte_is_blank(c)) addr_bad = 1'b1;
      end
    endcase

    if (fin) begin
      // never reaching the domain covers empty and all-whitespace input
      ok = !addr_bad && (scan_ph == PH_DOMAIN || scan_ph == PH_TRAIL) &&
           lab_cnt != 0 && prev_kind != KIND_HYPHEN && dot_seen;
      pending_verdicts.insert(pending_verdicts.size(), ok);
      clear_scan();
    end
  endtask

  // ---------------------------------------------------------------------------
  // drivers: all changes at the falling edge, handshakes seen at the rising edge
  // ---------------------------------------------------------------------------

  // send one byte, then maybe open a gap before the next burst
  task automatic send_byte(input logic [7:0] c, input logic fin);
    int gap;
    in_ch.valid      <= 1'b1;
    in_ch.text_byte  <= c;
    in_ch.final_byte <= fin;
    do @(posedge clk_i); while (!in_ch.ready);
    judge_byte(c, fin);
    bytes_sent++;
    @(negedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // valid stays high across a zero gap, so no low-high pair in one step
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(0, 40);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
  endtask

  task automatic send_address();
    for (int i = 0; i < addr_q.size(); i++) begin
      send_byte(addr_q[i], i == addr_q.size() - 1);
    end
  endtask

  // stop sending and wait for every verdict, then let the pipeline settle
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // one register write; the extra falling edge keeps valid low for a cycle
  task automatic write_cfg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata     <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (idx)
      CFG_LOCAL_LIMIT:  lim_local  = data[LocalLimitW-1:0];
      CFG_DOMAIN_LIMIT: lim_domain = data[DomainLimitW-1:0];
      CFG_LABEL_LIMIT:  lim_label  = data[LabelLimitW-1:0];
      default: ;
    endcase
    limit_writes++;
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // address generator
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] random_blank();
    return BLANKS[$urandom_range(0, 3)*8 +: 8];
  endfunction

  function automatic logic [7:0] random_alnum();
    int r;
    r = $urandom_range(0, 61);
    if (r < 10) return 8'("0" + r);
    if (r < 36) return 8'("A" + r - 10);
    return 8'("a" + r - 36);
  endfunction

  function automatic logic [7:0] random_local_char();
    if ($urandom_range(0, 9) < 6) return random_alnum();
    return SPECIALS[$urandom_range(0, N_SPECIALS - 1)*8 +: 8];
  endfunction

  // mostly short parts; now and then right at or one past the limit
  function automatic int pick_len(input int lim);
    int r;
    r = $urandom_range(0, 99);
    if ((lim <= 16 && r < 35) || r < 4) begin
      if (lim < 1) return 1;
      return lim + $urandom_range(0, 1);
    end
    return $urandom_range(1, 6);
  endfunction

  // well-formed address into addr_q; zero sizes mean random, may_mutate breaks it
  task automatic build_address(input int loc_len, input int n_labels, input int lab_len,
                               input bit may_mutate);
    int n;
    int len;
    int lead_n;
    int at_pos;
    int dom_end;
    int pos;
    addr_q.delete();
    lead_n = $urandom_range(0, 2);
    repeat (lead_n) add_byte(random_blank());

    // local part: dots only between other characters, never two in a row
    len = (loc_len > 0) ? loc_len : pick_len(int'(lim_local));
    for (int i = 0; i < len; i++) begin
      if (i > 0 && i < len - 1 && addr_q[$] != ChDot && $urandom_range(0, 4) == 0)
        add_byte(ChDot);
      else
        add_byte(random_local_char());
    end
    at_pos = addr_q.size();
    add_byte(ChAt);

    // domain: a single label now and then, which lacks the dot
    if (n_labels > 0) n = n_labels;
    else n = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 4);
    for (int l = 0; l < n; l++) begin
      if (l > 0) add_byte(ChDot);
      len = (lab_len > 0) ? lab_len : pick_len(int'(lim_label));
      for (int i = 0; i < len; i++) begin
        if (i > 0 && i < len - 1 && $urandom_range(0, 4) == 0) add_byte(ChHyphen);
        else add_byte(random_alnum());
      end
    end
    dom_end = addr_q.size();
    repeat ($urandom_range(0, 2)) add_byte(random_blank());

    if (may_mutate && $urandom_range(0, 99) < 30) begin
      case (mutation_e'($urandom_range(0, 7)))
        MUT_FLIP: begin
          pos = $urandom_range(0, addr_q.size() - 1);
          addr_q[pos] = 8'($urandom_range(0, 255));
        end
        MUT_INSERT: addr_q.insert($urandom_range(0, addr_q.size()), 8'($urandom_range(0, 255)));
        MUT_DROP: begin
          if (addr_q.size() > 1) addr_q.delete($urandom_range(0, addr_q.size() - 1));
        end
        MUT_SECOND_AT: addr_q.insert($urandom_range(at_pos + 1, addr_q.size()), ChAt);
        MUT_DOT_AT_EDGE: begin
          // leading or trailing dot of the local part, or of the domain
          case ($urandom_range(0, 3))
            0:       pos = lead_n;
            1:       pos = at_pos;
            2:       pos = at_pos + 1;
            default: pos = dom_end;
          endcase
          addr_q.insert(pos, ChDot);
        end
        MUT_HYPHEN_AT_EDGE: begin
          addr_q.insert(($urandom_range(0, 1) == 0) ? at_pos + 1 : dom_end, ChHyphen);
        end
        MUT_INNER_BLANK: addr_q.insert($urandom_range(lead_n + 1, dom_end - 1), random_blank());
        default: begin
          pos = $urandom_range(lead_n, dom_end);
          addr_q.insert(pos, ChDot);
          addr_q.insert(pos, ChDot);
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // result checker: each accepted verdict against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected verdict, expected none, actual address_ok=%0b",
                 $realtime, out_ch.address_ok);
        error_count++;
      end else begin
        if (out_ch.address_ok !== pending_verdicts[0]) begin
          $display("%0t: verdict mismatch, expected address_ok=%0b, actual address_ok=%0b",
                   $realtime, pending_verdicts[0], out_ch.address_ok);
          error_count++;
        end
        void'(pending_verdicts.pop_front());
      end
      addresses_checked++;
      if (out_ch.address_ok === 1'b1) valid_seen++;
    end
  end

  // receiver stalls in segments of random style and length, open stretches included
  initial begin : result_stall
    rx_mode_e mode;
    int seg_left;
    int period;
    int tick;
    out_ch.ready = 1'b0;
    mode     = RX_OPEN;
    seg_left = 0;
    period   = 2;
    tick     = 0;
    forever begin
      @(negedge clk_i);
      if (seg_left == 0) begin
        mode     = rx_mode_e'($urandom_range(0, 3));
        seg_left = $urandom_range(16, 160);
        period   = $urandom_range(2, 7);
      end
      seg_left--;
      tick++;
      case (mode)
        RX_OPEN:  out_ch.ready <= 1'b1;
        RX_COIN:  out_ch.ready <= ($urandom_range(0, 1) == 1);
        RX_TIGHT: out_ch.ready <= ($urandom_range(0, 3) == 0);
        default:  out_ch.ready <= (tick % period == 0);
      endcase
    end
  end

  // watchdog
  int cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d verdicts outstanding",
               $realtime, cycle_count, pending_verdicts.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // short hand-picked items at the reset limits
  task automatic test_directed_cases();
    // tab before, lf and cr after a minimal good address
    addr_q = '{8'h09, "a", ChAt, "b", ChDot, "c", 8'h0A, 8'h0D};
    send_address();
    // nothing but whitespace
    addr_q = '{8'h20};
    send_address();
    // whitespace inside the local part, no at sign
    addr_q = '{"a", 8'h20, "b"};
    send_address();
    // second at sign
    addr_q = '{"a", ChAt, ChAt, "b", ChDot, "c"};
    send_address();
    // stray byte after trailing whitespace
    addr_q = '{"a", ChAt, "b", ChDot, "c", 8'h20, "x"};
    send_address();
    // byte extremes, each a whole address
    addr_q = '{8'hFF};
    send_address();
    addr_q = '{8'h00};
    send_address();
  endtask

  // lengths at and one past the reset limits, before any register write
  task automatic test_reset_limit_edges();
    build_address(64, 2, 3, 1'b0);  send_address();
    build_address(65, 2, 3, 1'b0);  send_address();
    build_address(1, 4, 63, 1'b0);  send_address();  // domain exactly 255
    build_address(1, 2, 64, 1'b0);  send_address();
    build_address(1, 5, 51, 1'b0);  send_address();  // domain of 259
  endtask

  // zero, one, all-ones and masked register values
  task automatic test_limit_extremes();
    wait_idle();
    write_cfg(CFG_LOCAL_LIMIT, 8'h00);
    write_cfg(CFG_DOMAIN_LIMIT, 8'h00);
    write_cfg(CFG_LABEL_LIMIT, 8'h00);
    repeat (4) begin
      build_address(0, 0, 0, 1'b0);
      send_address();
    end

    // smallest limits that still let a good address through
    wait_idle();
    write_cfg(CFG_LOCAL_LIMIT, 8'd1);
    write_cfg(CFG_DOMAIN_LIMIT, 8'd3);
    write_cfg(CFG_LABEL_LIMIT, 8'd1);
    build_address(1, 2, 1, 1'b0);  send_address();
    build_address(2, 2, 1, 1'b0);  send_address();
    build_address(1, 2, 2, 1'b0);  send_address();

    // all ones: widest local part, upper data bits dropped on the narrow registers
    wait_idle();
    write_cfg(CFG_LOCAL_LIMIT, 8'hFF);
    write_cfg(CFG_DOMAIN_LIMIT, 8'hFF);
    write_cfg(CFG_LABEL_LIMIT, 8'hFF);
    write_cfg(CFG_UNUSED, 8'hFF);
    build_address(127, 2, 2, 1'b0);  send_address();
    build_address(128, 2, 2, 1'b0);  send_address();

    // only bit 7 set reads back as a zero local limit
    wait_idle();
    write_cfg(CFG_LOCAL_LIMIT, 8'h80);
    build_address(1, 2, 2, 1'b0);  send_address();
  endtask

  // phases of random limits, mostly small; mutated addresses and raw noise
  task automatic test_random_traffic();
    int start_bytes;
    int n_addr;
    start_bytes = bytes_sent;
    while (bytes_sent - start_bytes < RANDOM_BYTES) begin
      wait_idle();
      write_cfg(CFG_LOCAL_LIMIT,
                ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(1, 10)));
      write_cfg(CFG_DOMAIN_LIMIT,
                ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(2, 24)));
      write_cfg(CFG_LABEL_LIMIT,
                ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(1, 8)));
      if ($urandom_range(0, 3) == 0) write_cfg(CFG_UNUSED, 8'($urandom_range(0, 255)));
      n_addr = $urandom_range(8, 24);
      repeat (n_addr) begin
        // now and then hold off until the pipeline is empty
        if ($urandom_range(0, 29) == 0) wait_idle();
        if ($urandom_range(0, 4) == 0) begin
          addr_q.delete();
          repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(0, 255)));
        end else begin
          build_address(0, 0, 0, 1'b1);
        end
        send_address();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    in_ch.valid      = 1'b0;
    in_ch.text_byte  = '0;
    in_ch.final_byte = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.reg_index = CFG_LOCAL_LIMIT;
    cfg_ch.wdata     = '0;
    rst_ni           = 1'b0;
    error_count       = 0;
    bytes_sent        = 0;
    addresses_checked = 0;
    valid_seen        = 0;
    limit_writes      = 0;
    burst_left        = 0;
    lim_local  = LocalLimitReset;
    lim_domain = DomainLimitReset;
    lim_label  = LabelLimitReset;
    clear_scan();

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed_cases();
    test_reset_limit_edges();
    test_limit_extremes();
    test_random_traffic();

    wait_idle();
    repeat (TAIL_CYCLES) @(negedge clk_i);

    if (pending_verdicts.size() != 0) begin
      $display("%0t: %0d expected verdicts never arrived", $realtime, pending_verdicts.size());
      error_count++;
    end
    $display("covered %0d bytes in %0d addresses (%0d judged valid) over %0d register writes",
             bytes_sent, addresses_checked, valid_seen, limit_writes);
    $display("limits ran from zero through reset values to all ones, with random back-pressure");
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d checks failed", error_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
